// File: rtl/bmg_pkg.sv
// shared types, constants and tables of the box-muller gaussian generator
package bmg_pkg;

   localparam int UNIFORM_BITS_DEF  = 53;
   localparam int OUT_FRAC_BITS_DEF = 28;

   localparam logic [63:0] LCG_MUL     = 64'd6364136223846793005;
   localparam logic [63:0] LCG_INC     = 64'd1442695040888963407;
   localparam logic [31:0] TWO_LN2_Q29 = 32'd744261118;
   localparam logic [31:0] TWO_PI_Q29  = 32'd3373259426;
   localparam logic [63:0] SCALE_RESET = 64'h0000_0000_8000_0000;

   localparam logic [1:0] CSR_SEED_IDX  = 2'd0;
   localparam logic [1:0] CSR_SCALE_IDX = 2'd1;

   localparam int TERM_COUNT = 10;

   typedef enum logic [4:0] {
      OP_NOP, OP_START, OP_LCG0, OP_LCG1, OP_LCG2, OP_NORM, OP_SQR,
      OP_LN0, OP_LN1, OP_ROOT0, OP_ROOT, OP_ANG, OP_A2,
      OP_T0, OP_T1, OP_T2, OP_Z, OP_OUT
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LCG, ST_NORM, ST_LOG, ST_LN, ST_ROOT, ST_COS, ST_TERM, ST_Z, ST_OUT
   } state_type;

   typedef struct packed {
      op_type     op;
      logic [4:0] idx;
      logic       restart;
   } cmd_type;

   // taylor divisor (2n-1)(2n) for term n = idx+1
   function automatic logic [8:0] term_div(input logic [3:0] idx);
      logic [8:0] d;
      case (idx)
         4'd0:    d = 9'd2;
         4'd1:    d = 9'd12;
         4'd2:    d = 9'd30;
         4'd3:    d = 9'd56;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd132;
         4'd6:    d = 9'd182;
         4'd7:    d = 9'd240;
         4'd8:    d = 9'd306;
         default: d = 9'd380;
      endcase
      return d;
   endfunction

   // floor(2^s / d), s = 31 + floor(log2 d)
   function automatic logic [31:0] term_recip(input logic [3:0] idx);
      logic [31:0] m;
      case (idx)
         4'd0:    m = 32'd2147483648;
         4'd1:    m = 32'd1431655765;
         4'd2:    m = 32'd1145324612;
         4'd3:    m = 32'd1227133513;
         4'd4:    m = 32'd1527099483;
         4'd5:    m = 32'd2082408385;
         4'd6:    m = 32'd1510318170;
         4'd7:    m = 32'd1145324612;
         4'd8:    m = 32'd1796587627;
         default: m = 32'd1446725826;
      endcase
      return m;
   endfunction

   function automatic logic [5:0] term_shift(input logic [3:0] idx);
      logic [5:0] s;
      case (idx)
         4'd0:    s = 6'd32;
         4'd1:    s = 6'd34;
         4'd2:    s = 6'd35;
         4'd3:    s = 6'd36;
         4'd4:    s = 6'd37;
         4'd5:    s = 6'd38;
         4'd6:    s = 6'd38;
         4'd7:    s = 6'd38;
         4'd8:    s = 6'd39;
         default: s = 6'd39;
      endcase
      return s;
   endfunction

endpackage

// File: rtl/bmg_ctrl.sv
// sequencer of the box-muller gaussian generator
module bmg_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_restart,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bmg_pkg::cmd_type cmd
);

   localparam logic [4:0] LCG_LAST  = 5'd1;
   localparam logic [4:0] NORM_LAST = 5'd5;
   localparam logic [4:0] LOG_LAST  = 5'd27;
   localparam logic [4:0] ROOT_LAST = 5'd31;
   localparam logic [4:0] TERM_LAST = 5'(bmg_pkg::TERM_COUNT - 1);

   bmg_pkg::state_type state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [1:0] phase_ff, phase_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bmg_pkg::ST_IDLE;
         cnt_ff       <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      req_ready    = 1'b0;
      cmd.op       = bmg_pkg::OP_NOP;
      cmd.idx      = cnt_ff;
      cmd.restart  = 1'b0;
      case (state_ff)
         bmg_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op      = bmg_pkg::OP_START;
               cmd.restart = req_restart;
               state_in    = bmg_pkg::ST_LCG;
               cnt_in      = '0;
               phase_in    = '0;
            end
         end
         bmg_pkg::ST_LCG: begin
            case (phase_ff)
               2'd0:    cmd.op = bmg_pkg::OP_LCG0;
               2'd1:    cmd.op = bmg_pkg::OP_LCG1;
               default: cmd.op = bmg_pkg::OP_LCG2;
            endcase
            if (phase_ff == 2'd2) begin
               phase_in = '0;
               cnt_in   = cnt_ff + 5'd1;
               if (cnt_ff == LCG_LAST) begin
                  cnt_in   = '0;
                  state_in = bmg_pkg::ST_NORM;
               end
            end else begin
               phase_in = phase_ff + 2'd1;
            end
         end
         bmg_pkg::ST_NORM: begin
            cmd.op = bmg_pkg::OP_NORM;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == NORM_LAST) begin
               cnt_in   = '0;
               state_in = bmg_pkg::ST_LOG;
            end
         end
         bmg_pkg::ST_LOG: begin
            cmd.op = bmg_pkg::OP_SQR;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == LOG_LAST) begin
               cnt_in   = '0;
               phase_in = '0;
               state_in = bmg_pkg::ST_LN;
            end
         end
         bmg_pkg::ST_LN: begin
            case (phase_ff)
               2'd0:    cmd.op = bmg_pkg::OP_LN0;
               2'd1:    cmd.op = bmg_pkg::OP_LN1;
               default: cmd.op = bmg_pkg::OP_ROOT0;
            endcase
            phase_in = phase_ff + 2'd1;
            if (phase_ff == 2'd2) begin
               phase_in = '0;
               cnt_in   = '0;
               state_in = bmg_pkg::ST_ROOT;
            end
         end
         bmg_pkg::ST_ROOT: begin
            cmd.op = bmg_pkg::OP_ROOT;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == ROOT_LAST) begin
               cnt_in   = '0;
               phase_in = '0;
               state_in = bmg_pkg::ST_COS;
            end
         end
         bmg_pkg::ST_COS: begin
            cmd.op   = (phase_ff == 2'd0) ? bmg_pkg::OP_ANG : bmg_pkg::OP_A2;
            phase_in = phase_ff + 2'd1;
            if (phase_ff != 2'd0) begin
               phase_in = '0;
               cnt_in   = '0;
               state_in = bmg_pkg::ST_TERM;
            end
         end
         bmg_pkg::ST_TERM: begin
            case (phase_ff)
               2'd0:    cmd.op = bmg_pkg::OP_T0;
               2'd1:    cmd.op = bmg_pkg::OP_T1;
               default: cmd.op = bmg_pkg::OP_T2;
            endcase
            if (phase_ff == 2'd2) begin
               phase_in = '0;
               cnt_in   = cnt_ff + 5'd1;
               if (cnt_ff == TERM_LAST) begin
                  cnt_in   = '0;
                  state_in = bmg_pkg::ST_Z;
               end
            end else begin
               phase_in = phase_ff + 2'd1;
            end
         end
         bmg_pkg::ST_Z: begin
            cmd.op   = bmg_pkg::OP_Z;
            state_in = bmg_pkg::ST_OUT;
         end
         bmg_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = bmg_pkg::OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = bmg_pkg::ST_IDLE;
            end
         end
         default: state_in = bmg_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/bmg_datapath.sv
// datapath of the box-muller gaussian generator around one shared 32x32 multiplier
module bmg_datapath #(
   parameter int UNIFORM_BITS  = bmg_pkg::UNIFORM_BITS_DEF,
   parameter int OUT_FRAC_BITS = bmg_pkg::OUT_FRAC_BITS_DEF
) (
   input  logic                clock,
   input  bmg_pkg::cmd_type    cmd,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [63:0]         csr_wdata,
   output logic signed [31:0]  rsp_sample
);

   localparam int UB = UNIFORM_BITS;
   localparam logic [63:0] U1_MIN64 = ((64'd1 << UB) + 64'd9999999) / 64'd10000000;
   localparam logic [UB-1:0] U1_MIN = U1_MIN64[UB-1:0];
   localparam logic [UB-2:0] QUARTER = (UB-1)'(1) << (UB - 2);
   localparam int TURN_R = (UB >= 30) ? UB - 30 : 0;
   localparam int TURN_L = (UB >= 30) ? 0 : 30 - UB;
   localparam logic [5:0] UB6 = 6'(UB);
   localparam int OUT_SH = 59 - OUT_FRAC_BITS;
   localparam logic [64:0] OUT_RND = 65'd1 << (58 - OUT_FRAC_BITS);

   logic [63:0] seed_ff, scale_ff;
   logic [63:0] lcg_ff, acc_ff;
   logic [63:0] x_ff;
   logic [5:0]  k_ff;
   logic [UB-1:0] u2_ff;
   logic [31:0] y_ff;
   logic [27:0] frac_ff;
   logic [63:0] v_ff, res_ff;
   logic [30:0] ang_ff;
   logic [31:0] a2_ff, term_ff, nq_ff, q0_ff, z_ff;
   logic signed [33:0] sum_ff;
   logic [31:0] sample_ff;

   // shared multiplier
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;
   assign prod = mul_a * mul_b;

   logic [63:0] lcg_next;
   logic [UB-1:0] u_new;
   logic [6:0]  norm_sh;
   logic [31:0] y_src;
   logic [32:0] sq;
   logic [34:0] t_val;
   logic [63:0] root_bit, root_try;
   logic [63:0] acc_rnd;
   logic [1:0]  quad;
   logic [UB-2:0] off;
   logic [63:0] turns64;
   logic [3:0]  tidx;
   logic [8:0]  tdiv;
   logic [31:0] rem, qv;
   logic [30:0] cos_c;
   logic [63:0] z_rnd;
   logic [64:0] mag;
   logic        neg;

   always_comb begin
      lcg_next = acc_ff + {prod[31:0], 32'd0};
      u_new    = lcg_next[63 -: UB];
      norm_sh  = 7'd32 >> cmd.idx[2:0];
      y_src    = (cmd.idx == 5'd0) ? x_ff[63:32] : y_ff;
      sq       = prod[63:31];
      t_val    = 35'({UB6 - k_ff, 28'd0}) - 35'(frac_ff);
      acc_rnd  = acc_ff + (64'd1 << 28);
      root_bit = 64'd1 << (7'd62 - 7'({cmd.idx, 1'b0}));
      root_try = res_ff + root_bit;
      quad     = u2_ff[UB-1 -: 2];
      off      = (UB-1)'(u2_ff[UB-3:0]);
      if (quad[0]) off = QUARTER - off;
      turns64  = (64'(off) >> TURN_R) << TURN_L;
      tidx     = cmd.idx[3:0];
      tdiv     = bmg_pkg::term_div(tidx);
      rem      = nq_ff - prod[31:0];
      qv       = q0_ff + ((rem >= 32'(tdiv)) ? 32'd1 : 32'd0);
      if (sum_ff < 0) cos_c = '0;
      else if (sum_ff > 34'sd1073741824) cos_c = 31'd1073741824;
      else cos_c = sum_ff[30:0];
      z_rnd    = prod + (64'd1 << 29);
      mag      = ({1'b0, prod} + OUT_RND) >> OUT_SH;
      neg      = (quad == 2'd1) || (quad == 2'd2);

      case (cmd.op)
         bmg_pkg::OP_LCG0: begin mul_a = lcg_ff[31:0];  mul_b = bmg_pkg::LCG_MUL[31:0];  end
         bmg_pkg::OP_LCG1: begin mul_a = lcg_ff[31:0];  mul_b = bmg_pkg::LCG_MUL[63:32]; end
         bmg_pkg::OP_LCG2: begin mul_a = lcg_ff[63:32]; mul_b = bmg_pkg::LCG_MUL[31:0];  end
         bmg_pkg::OP_SQR:  begin mul_a = y_src;         mul_b = y_src;                  end
         bmg_pkg::OP_LN0:  begin mul_a = t_val[31:0];   mul_b = bmg_pkg::TWO_LN2_Q29;   end
         bmg_pkg::OP_LN1: begin
            mul_a = 32'(t_val[34:32]);
            mul_b = bmg_pkg::TWO_LN2_Q29;
         end
         bmg_pkg::OP_ANG:  begin mul_a = turns64[31:0]; mul_b = bmg_pkg::TWO_PI_Q29;    end
         bmg_pkg::OP_A2:   begin mul_a = 32'(ang_ff);   mul_b = 32'(ang_ff);            end
         bmg_pkg::OP_T0:   begin mul_a = term_ff;       mul_b = a2_ff;                  end
         bmg_pkg::OP_T1:   begin mul_a = nq_ff;  mul_b = bmg_pkg::term_recip(tidx);     end
         bmg_pkg::OP_T2:   begin mul_a = q0_ff;         mul_b = 32'(tdiv);              end
         bmg_pkg::OP_Z:    begin mul_a = res_ff[31:0];  mul_b = 32'(cos_c);             end
         bmg_pkg::OP_OUT:  begin mul_a = z_ff;          mul_b = scale_ff[31:0];         end
         default:          begin mul_a = '0;            mul_b = '0;                     end
      endcase
   end

   // configuration registers and generator state
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= '0;
         scale_ff <= bmg_pkg::SCALE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            bmg_pkg::CSR_SEED_IDX:  seed_ff  <= csr_wdata;
            bmg_pkg::CSR_SCALE_IDX: scale_ff <= {32'd0, csr_wdata[31:0]};
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lcg_ff <= '0;
      end else if (cmd.op == bmg_pkg::OP_START && cmd.restart) begin
         lcg_ff <= seed_ff;
      end else if (cmd.op == bmg_pkg::OP_LCG2) begin
         lcg_ff <= lcg_next;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         bmg_pkg::OP_LCG0: acc_ff <= prod + bmg_pkg::LCG_INC;
         bmg_pkg::OP_LCG1: acc_ff <= acc_ff + {prod[31:0], 32'd0};
         bmg_pkg::OP_LCG2: begin
            if (cmd.idx == 5'd0) begin
               x_ff <= 64'((u_new < U1_MIN) ? U1_MIN : u_new);
               k_ff <= 6'd63;
            end else begin
               u2_ff <= u_new;
            end
         end
         bmg_pkg::OP_NORM: begin
            if ((x_ff >> (7'd64 - norm_sh)) == 64'd0) begin
               x_ff <= x_ff << norm_sh;
               k_ff <= k_ff - norm_sh[5:0];
            end
         end
         bmg_pkg::OP_SQR: begin
            // squaring gives one fraction bit of log2 a step
            if (sq[32]) begin
               y_ff    <= sq[32:1];
               frac_ff <= {((cmd.idx == 5'd0) ? 27'd0 : frac_ff[26:0]), 1'b1};
            end else begin
               y_ff    <= sq[31:0];
               frac_ff <= {((cmd.idx == 5'd0) ? 27'd0 : frac_ff[26:0]), 1'b0};
            end
         end
         bmg_pkg::OP_LN0:   acc_ff <= prod;
         bmg_pkg::OP_LN1:   acc_ff <= acc_ff + {prod[31:0], 32'd0};
         bmg_pkg::OP_ROOT0: begin
            v_ff   <= {acc_rnd[63:29], 28'd0} & 64'h7FFF_FFFF_FFFF_FFFF;
            res_ff <= '0;
         end
         bmg_pkg::OP_ROOT: begin
            if (v_ff >= root_try) begin
               v_ff   <= v_ff - root_try;
               res_ff <= (res_ff >> 1) + root_bit;
            end else begin
               res_ff <= res_ff >> 1;
            end
         end
         bmg_pkg::OP_ANG: ang_ff <= prod[59:29];
         bmg_pkg::OP_A2: begin
            a2_ff   <= prod[61:30];
            term_ff <= 32'd1073741824;
            sum_ff  <= 34'sd1073741824;
         end
         bmg_pkg::OP_T0: nq_ff <= prod[61:30];
         bmg_pkg::OP_T1: q0_ff <= 32'(prod >> bmg_pkg::term_shift(tidx));
         bmg_pkg::OP_T2: begin
            term_ff <= qv;
            if (tidx[0]) sum_ff <= sum_ff + $signed({2'b00, qv});
            else sum_ff <= sum_ff - $signed({2'b00, qv});
         end
         bmg_pkg::OP_Z: z_ff <= z_rnd[61:30];
         bmg_pkg::OP_OUT: begin
            if (neg) begin
               sample_ff <= (mag > 65'h8000_0000) ? 32'h8000_0000 : (32'd0 - mag[31:0]);
            end else begin
               sample_ff <= (mag > 65'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
            end
         end
         default: ;
      endcase
   end

   assign rsp_sample = $signed(sample_ff);

endmodule

// File: rtl/box_muller_gaussian_generator.sv
// top level of the box-muller gaussian generator: sequencer plus datapath
//
//  channel   direction   handshake              payload
//  req       in          req_valid/req_ready    req_restart
//  rsp       out         rsp_valid/rsp_ready    rsp_sample (signed q3.28)
//  csr       in          csr_we                 csr_index, csr_wdata
//
// a transaction runs from acceptance to a posted result through the lcg,
// normalise, log squaring, scaling, root, angle, taylor, product and gain steps,
// bounded by the shared 32x32 multiplier and the one-bit-a-step square root and
// log. one transaction is in work at a time, and the next request can be taken
// in the cycle the result is posted.
// reset is synchronous and active high; seed clears, gain returns to 1.0.
// a finished sample waits in the output register while the next request
// is taken; the sequencer only stalls at the gain step if it is still held.
module box_muller_gaussian_generator #(
   parameter int UNIFORM_BITS  = bmg_pkg::UNIFORM_BITS_DEF,
   parameter int OUT_FRAC_BITS = bmg_pkg::OUT_FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_restart,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_sample,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [63:0]        csr_wdata
);

   // command word from sequencer to datapath
   bmg_pkg::cmd_type cmd;

   bmg_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_restart (req_restart),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .cmd         (cmd)
   );

   // lcg, log, root and cosine arithmetic plus the config registers
   bmg_datapath #(
      .UNIFORM_BITS  (UNIFORM_BITS),
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
   ) u_dp (
      .clock      (clock),
      .cmd        (cmd),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_sample (rsp_sample)
   );

endmodule

// File: rtl/bmg_checker.sv
// port-level checks of the box-muller gaussian generator, bound to the top level
module bmg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_sample
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_sample))
      else $error("result changed while stalled");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in work");

   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result appeared right after acceptance");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind box_muller_gaussian_generator bmg_checker u_bmg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_sample (rsp_sample)
);

// File: tb/tb.sv
// self-checking testbench for the box-muller gaussian generator
module tb;

   localparam int UB  = bmg_pkg::UNIFORM_BITS_DEF;
   localparam int OFB = bmg_pkg::OUT_FRAC_BITS_DEF;
   localparam logic [63:0] U1_FLOOR = ((64'd1 << UB) + 64'd9999999) / 64'd10000000;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int N_RANDOM = 1620;
   localparam logic [1:0] CSR_UNUSED_IDX = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_restart = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_sample;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = bmg_pkg::CSR_SEED_IDX;
   logic [63:0] csr_wdata = '0;

   always #5 clock = ~clock;

   box_muller_gaussian_generator u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_restart(req_restart),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_sample(rsp_sample),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // predictor state: shadow registers and generator
   logic [63:0] seed_shadow;
   logic [31:0] gain_shadow;
   logic [63:0] lcg_shadow;

   logic restart_queue[$];        // pending request transactions
   logic signed [31:0] sample_queue[$];  // expected samples in order
   int errors = 0;
   int n_sent = 0, n_checked = 0, n_restart = 0, n_sat = 0;
   int idle_cycles = 0;

   function automatic logic [63:0] lcg_next(input logic [63:0] s);
      return s * bmg_pkg::LCG_MUL + bmg_pkg::LCG_INC;
   endfunction

   // multiplicative inverse of the lcg multiplier mod 2^64, newton iteration
   function automatic logic [63:0] lcg_mul_inverse();
      logic [63:0] inv;
      inv = bmg_pkg::LCG_MUL;
      for (int i = 0; i < 5; i++) inv = inv * (64'd2 - bmg_pkg::LCG_MUL * inv);
      return inv;
   endfunction

   // seed whose first lcg step lands on the given state
   function automatic logic [63:0] seed_for_state(input logic [63:0] target);
      return (target - bmg_pkg::LCG_INC) * lcg_mul_inverse();
   endfunction

   // -log2(m / 2^ub) in q28
   function automatic logic [63:0] neg_log2(input logic [63:0] m);
      int k;
      logic [63:0] y, frac;
      k = 0;
      frac = 0;
      while (k < 63 && (m >> (k + 1)) != 0) k++;
      y = (k <= 31) ? (m << (31 - k)) : (m >> (k - 31));
      for (int i = 0; i < 28; i++) begin
         y = (y * y) >> 31;
         frac = frac << 1;
         if (y >= (64'd1 << 32)) begin
            y = y >> 1;
            frac[0] = 1'b1;
         end
      end
      return (64'(UB - k) << 28) - frac;
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // taylor cosine, q30 in and out, clamped to [0, 1]
   function automatic logic [63:0] cosine_q30(input logic [63:0] ang);
      logic [63:0] a2, term;
      longint sum;
      a2 = (ang * ang) >> 30;
      term = 64'd1 << 30;
      sum = longint'(64'd1 << 30);
      for (int n = 1; n <= 10; n++) begin
         term = ((term * a2) >> 30) / 64'((2 * n - 1) * (2 * n));
         if (n % 2 == 1) sum -= longint'(term);
         else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > longint'(64'd1 << 30)) sum = longint'(64'd1 << 30);
      return 64'(sum);
   endfunction

   // advance the shadow generator and work out the next gaussian sample
   function automatic logic signed [31:0] next_gaussian(input logic restart);
      logic [63:0] u1, u2, t, l, r, quad, off, quarter, turns, ang, c, z, mag;
      logic neg;
      if (restart) lcg_shadow = seed_shadow;
      lcg_shadow = lcg_next(lcg_shadow);
      u1 = (lcg_shadow >> 11) >> (53 - UB);
      lcg_shadow = lcg_next(lcg_shadow);
      u2 = (lcg_shadow >> 11) >> (53 - UB);
      if (u1 < U1_FLOOR) u1 = U1_FLOOR;
      t = neg_log2(u1);
      l = (t * 64'(bmg_pkg::TWO_LN2_Q29) + (64'd1 << 28)) >> 29;
      r = int_sqrt(l << 28);
      quarter = 64'd1 << (UB - 2);
      quad = u2 >> (UB - 2);
      off = u2 & (quarter - 1);
      if (quad[0]) off = quarter - off;
      neg = (quad == 1 || quad == 2);
      turns = (UB >= 30) ? (off >> (UB - 30)) : (off << (30 - UB));
      ang = (turns * 64'(bmg_pkg::TWO_PI_Q29)) >> 29;
      c = cosine_q30(ang);
      z = (r * c + (64'd1 << 29)) >> 30;
      mag = (z * 64'(gain_shadow) + (64'd1 << (58 - OFB))) >> (59 - OFB);
      if (neg) begin
         if (mag > (64'd1 << 31)) begin
            mag = 64'd1 << 31;
            n_sat++;
         end
         return 32'(-mag);
      end
      if (mag > 64'h7FFF_FFFF) begin
         mag = 64'h7FFF_FFFF;
         n_sat++;
      end
      return 32'(mag);
   endfunction

   // driver: bursts of back-to-back transactions separated by random gaps
   int burst_left = 0, gap_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sample_queue.push_back(next_gaussian(req_restart));
            if (req_restart) n_restart++;
            n_sent++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (restart_queue.size() > 0) begin
               req_valid <= 1'b1;
               req_restart <= restart_queue.pop_front();
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 12);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver stall pattern
   int stall_mode = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (sample_queue.size() == 0) begin
               $error("unexpected sample transaction: sample actual %0d", rsp_sample);
               errors++;
            end else begin
               logic signed [31:0] want;
               want = sample_queue.pop_front();
               if (rsp_sample !== want) begin
                  $error("sample mismatch: expected %0d actual %0d", want, rsp_sample);
                  errors++;
               end
               n_checked++;
            end
         end
         if ($urandom_range(0, 299) == 0) stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 1) == 0);
            2: rsp_ready <= ($urandom_range(0, 7) == 0);
            default: rsp_ready <= ($urandom_range(0, 99) < 95);
         endcase
      end
   end

   // watchdog on cycles with no accepted transaction
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("box_muller_gaussian_generator verification failed");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == bmg_pkg::CSR_SEED_IDX) seed_shadow = value;
      else if (idx == bmg_pkg::CSR_SCALE_IDX) gain_shadow = value[31:0];
   endtask

   // wait for the queues to drain, plus the pipeline depth
   task automatic drain();
      while (restart_queue.size() > 0 || sample_queue.size() > 0 || req_valid)
         @(posedge clock);
      repeat (130) @(posedge clock);
   endtask

   task automatic run_phase(input int count, input int restart_pct);
      for (int i = 0; i < count; i++)
         restart_queue.push_back($urandom_range(0, 99) < restart_pct);
      drain();
   endtask

   initial begin
      seed_shadow = '0;
      gain_shadow = 32'h8000_0000;
      lcg_shadow = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: reset defaults, then restart from the zero seed
      for (int i = 0; i < 3; i++) restart_queue.push_back(1'b0);
      restart_queue.push_back(1'b1);
      drain();
      // first draw lands on state zero: u1 clamped, gain near two saturates high
      write_reg(bmg_pkg::CSR_SEED_IDX, seed_for_state(64'd0));
      write_reg(bmg_pkg::CSR_SCALE_IDX, 64'hFFFF_FFFF);
      for (int i = 0; i < 4; i++) restart_queue.push_back(i % 2 == 0);
      drain();
      // first draw lands on state one: u1 clamped, second quadrant saturates low
      write_reg(bmg_pkg::CSR_SEED_IDX, seed_for_state(64'd1));
      for (int i = 0; i < 2; i++) restart_queue.push_back(1'b1);
      drain();
      // u1 just under and exactly at the clamp floor
      write_reg(bmg_pkg::CSR_SEED_IDX, seed_for_state((U1_FLOOR - 64'd1) << (64 - UB)));
      for (int i = 0; i < 2; i++) restart_queue.push_back(1'b1);
      drain();
      write_reg(bmg_pkg::CSR_SEED_IDX, seed_for_state(U1_FLOOR << (64 - UB)));
      for (int i = 0; i < 2; i++) restart_queue.push_back(1'b1);
      drain();
      write_reg(bmg_pkg::CSR_SCALE_IDX, 64'd0);           // zero gain
      write_reg(bmg_pkg::CSR_SEED_IDX, 64'h0123_4567_89AB_CDEF);
      for (int i = 0; i < 4; i++) restart_queue.push_back(i == 0);
      drain();
      write_reg(bmg_pkg::CSR_SCALE_IDX, 64'd1);
      write_reg(CSR_UNUSED_IDX, 64'hDEAD_BEEF);            // unknown index, ignored
      for (int i = 0; i < 4; i++) restart_queue.push_back(i == 0);
      drain();

      // random phases over several gain and seed settings
      for (int p = 0; p < 9; p++) begin
         logic [63:0] s;
         logic [31:0] g;
         s = {$urandom, $urandom};
         case (p % 4)
            0: g = 32'h8000_0000;
            1: g = $urandom;
            2: g = 32'hFFFF_FFFF;
            default: g = $urandom_range(0, 32'h8000_0000);
         endcase
         if (p == 8) s = 64'd0;
         write_reg(bmg_pkg::CSR_SEED_IDX, s);
         write_reg(bmg_pkg::CSR_SCALE_IDX, {32'h0, g});
         run_phase(N_RANDOM / 9, 5);
      end

      $display("covered %0d requests (%0d restarts), %0d samples checked, %0d saturated",
               n_sent, n_restart, n_checked, n_sat);
      if (errors == 0 && sample_queue.size() == 0)
         $display("box_muller_gaussian_generator verification clean");
      else
         $display("box_muller_gaussian_generator verification failed");
      $finish;
   end
endmodule

// File: filelist.f
rtl/bmg_pkg.sv
rtl/bmg_ctrl.sv
rtl/bmg_datapath.sv
rtl/box_muller_gaussian_generator.sv
rtl/bmg_checker.sv
tb/tb.sv
